### rtl/sgs_pkg.sv
`timescale 1ns / 1ps

package sgs_pkg;

    // default configuration
    localparam int HALF_LEN_DEF     = 25;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // tap weight and weight step widths, wide enough for half windows up to 31
    localparam int WGT_W = 16;
    localparam int DLT_W = 12;

    // window register controls from the sequencer
    typedef struct packed {
        logic fill;
        logic shift;
        logic rotate;
    } win_ctrl_t;

endpackage

### rtl/savitzky_golay_smoother_with_slope_top.sv
`timescale 1ns / 1ps

// Quadratic Savitzky-Golay smoother with slope over a 2*HALF_LEN+1 window.
// Input channel s_*: one signed sample per item, s_tlast on the last sample of
// a record. Output channel m_*: smoothed value and its difference from the
// previous smoothed value of the record (0 on the first), m_tlast on the last.
// Output k leaves once sample k+HALF_LEN has been taken; the record's last
// sample flushes every pending output. Record edges read the first or last
// sample. Smoothed values round half up and saturate to SAMPLE_WIDTH bits.
// Each output passes through the shared multiply-accumulate, a setup state and
// the reciprocal divider, which takes longer when its estimate needs a
// correction step, before its result reaches the output register.
// s_tready is high only while the sequencer is idle; one item at a time. The
// next item is not taken until the sequencer is through with every output that
// the last one gave, flush outputs included. A finished output waits in the
// output register; while the receiver stalls, the sequencer holds at the next
// output.
// Reset (aresetn low, synchronous) drops the item in progress and any waiting
// output, and starts a new record.
module savitzky_golay_smoother_with_slope_top
    import sgs_pkg::*;
#(
    parameter int HALF_LEN     = HALF_LEN_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // sample
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]            s_tdata,
    // end_of_record
    input  logic                                         s_tlast,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // smoothed, slope
    output logic [((2*SAMPLE_WIDTH+1+7)/8)*8-1:0]        m_tdata,
    // final_output
    output logic                                         m_tlast
);

    localparam int SW      = SAMPLE_WIDTH;
    localparam int M       = HALF_LEN;
    localparam int WIN     = 2 * M + 1;
    localparam int DIVISOR = (2 * M - 1) * (2 * M + 1) * (2 * M + 3);
    localparam int ACC_W   = SW + 21;
    localparam int NUM_W   = ACC_W + 2;
    localparam int PROD_W  = SW + WGT_W;
    localparam int Q_W     = SW + 2;
    localparam int MW      = ((2 * SW + 1 + 7) / 8) * 8;
    localparam int CNT_W   = $clog2(WIN + 1);
    localparam int SEEN_W  = $clog2(M + 2);
    localparam int STEP_W  = $clog2(M + 1);
    localparam int CMP_W   = $clog2(2 * M + 2);
    localparam int W_FIRST = 3 * (3 * M * M + 3 * M - 1) - 15 * M * M;
    localparam int D_FIRST = 15 * (1 - 2 * M);

    localparam logic signed [WGT_W-1:0] WGT_INIT  = WGT_W'(W_FIRST);
    localparam logic signed [DLT_W-1:0] DLT_INIT  = DLT_W'(D_FIRST);
    localparam logic signed [DLT_W-1:0] DLT_STEP  = DLT_W'(30);
    localparam logic [SEEN_W-1:0]       SEEN_FULL = SEEN_W'(M + 1);
    localparam logic [STEP_W-1:0]       STEP_LAST = STEP_W'(M);
    localparam logic [CNT_W-1:0]        CNT_LAST  = CNT_W'(WIN);
    localparam logic [CMP_W-1:0]        CMP_EMIT  = CMP_W'(M + 1);
    localparam logic signed [NUM_W-1:0] NUM_BIAS  = NUM_W'(DIVISOR);
    localparam logic signed [Q_W:0]     SAT_HI    =
        $signed({{(Q_W + 2 - SW){1'b0}}, {(SW - 1){1'b1}}});
    localparam logic signed [Q_W:0]     SAT_LO    =
        $signed({{(Q_W + 2 - SW){1'b1}}, {(SW - 1){1'b0}}});

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_PREP,
        S_DIV,
        S_OUT,
        S_ADV
    } state_t;

    state_t                    state_reg;
    logic [SEEN_W-1:0]         seen_reg;
    logic [STEP_W-1:0]         step_reg;
    logic                      eor_reg;
    logic                      last_reg;
    logic                      first_reg;
    logic signed [SW-1:0]      x_reg;
    logic signed [SW-1:0]      prev_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic signed [WGT_W-1:0]   wgt_reg;
    logic signed [DLT_W-1:0]   dlt_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic                      m_tvalid_reg;
    logic signed [SW-1:0]      m_smoothed_reg;
    logic signed [SW:0]        m_slope_reg;
    logic                      m_last_reg;

    logic                      s_accept;
    logic signed [SW-1:0]      s_sample;
    logic [SEEN_W-1:0]         seen_next;
    logic [STEP_W-1:0]         step_next;
    logic                      flush_emit;
    logic                      out_load;
    win_ctrl_t                 win_ctrl;
    logic signed [SW-1:0]      win_din;
    logic signed [SW-1:0]      tap;
    logic signed [NUM_W-1:0]   div_num;
    logic                      div_done;
    logic signed [Q_W:0]       div_quot;
    logic signed [SW-1:0]      sm;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign s_sample = $signed(s_tdata[SW-1:0]);

    // samples of the record, saturating once the window is centered
    assign seen_next = (seen_reg == SEEN_FULL) ? seen_reg : seen_reg + 1'b1;
    assign step_next = step_reg + 1'b1;
    assign flush_emit = (CMP_W'(step_next) + CMP_W'(seen_reg)) >= CMP_EMIT;

    // output register takes a new result when it is free or being emptied
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    // window controls
    always_comb begin
        win_ctrl.fill   = s_accept && (seen_reg == '0);
        win_ctrl.shift  = (s_accept && (seen_reg != '0))
                       || ((state_reg == S_ADV) && eor_reg && (step_reg != STEP_LAST));
        win_ctrl.rotate = (state_reg == S_MAC) && (cnt_reg != CNT_LAST);
        win_din         = s_accept ? s_sample : x_reg;
    end

    sgs_window #(
        .WIN (WIN),
        .SW  (SW)
    ) u_window (
        .aclk (aclk),
        .ctrl (win_ctrl),
        .din  (win_din),
        .tap  (tap)
    );

    // rounding bias: floor((2*acc + D) / (2*D))
    assign div_num = (NUM_W'(acc_reg) <<< 1) + NUM_BIAS;

    sgs_divider #(
        .NUM_W   (NUM_W),
        .Q_W     (Q_W),
        .DIVISOR (DIVISOR)
    ) u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == S_PREP),
        .num     (div_num),
        .done    (div_done),
        .quot    (div_quot)
    );

    // saturate the rounded quotient
    always_comb begin
        if (div_quot > SAT_HI) begin
            sm = SAT_HI[SW-1:0];
        end else if (div_quot < SAT_LO) begin
            sm = SAT_LO[SW-1:0];
        end else begin
            sm = div_quot[SW-1:0];
        end
    end

    // sequencer, multiply-accumulate and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            seen_reg     <= '0;
            step_reg     <= '0;
            first_reg    <= 1'b1;
            prev_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        x_reg    <= s_sample;
                        eor_reg  <= s_tlast;
                        seen_reg <= seen_next;
                        step_reg <= '0;
                        last_reg <= 1'b0;
                        if (seen_next == SEEN_FULL) begin
                            cnt_reg   <= '0;
                            acc_reg   <= '0;
                            wgt_reg   <= WGT_INIT;
                            dlt_reg   <= DLT_INIT;
                            state_reg <= S_MAC;
                        end else begin
                            state_reg <= S_ADV;
                        end
                    end
                end
                S_MAC: begin
                    // weights follow w(i+1) = w(i) - 15(2i+1)
                    if (cnt_reg != CNT_LAST) begin
                        prod_reg <= wgt_reg * tap;
                        wgt_reg  <= wgt_reg - WGT_W'(dlt_reg);
                        dlt_reg  <= dlt_reg + DLT_STEP;
                    end else begin
                        state_reg <= S_PREP;
                    end
                    if (cnt_reg != '0) begin
                        acc_reg <= acc_reg + ACC_W'(prod_reg);
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
                S_PREP: begin
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        m_smoothed_reg <= sm;
                        m_slope_reg    <= first_reg ? '0
                                                    : (SW + 1)'(sm) - (SW + 1)'(prev_reg);
                        m_last_reg     <= last_reg;
                        prev_reg       <= sm;
                        first_reg      <= 1'b0;
                        state_reg      <= S_ADV;
                    end
                end
                S_ADV: begin
                    // flush: shift the last sample in again until the record ends
                    if (!eor_reg) begin
                        state_reg <= S_IDLE;
                    end else if (step_reg == STEP_LAST) begin
                        seen_reg  <= '0;
                        prev_reg  <= '0;
                        first_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end else begin
                        step_reg <= step_next;
                        if (flush_emit) begin
                            last_reg  <= (step_next == STEP_LAST);
                            cnt_reg   <= '0;
                            acc_reg   <= '0;
                            wgt_reg   <= WGT_INIT;
                            dlt_reg   <= DLT_INIT;
                            state_reg <= S_MAC;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(MW - 2 * SW - 1){1'b0}}, m_slope_reg, m_smoothed_reg};

endmodule

### rtl/sgs_window.sv
`timescale 1ns / 1ps

module sgs_window
    import sgs_pkg::*;
#(
    parameter int WIN = 2 * HALF_LEN_DEF + 1,
    parameter int SW  = SAMPLE_WIDTH_DEF
) (
    input  logic                 aclk,
    input  win_ctrl_t            ctrl,
    input  logic signed [SW-1:0] din,
    output logic signed [SW-1:0] tap
);

    logic signed [SW-1:0] win_reg [WIN];

    // fill on record start, shift in new samples, rotate while the taps are read
    always_ff @(posedge aclk) begin
        if (ctrl.fill) begin
            for (int i = 0; i < WIN; i++) begin
                win_reg[i] <= din;
            end
        end else if (ctrl.shift) begin
            for (int i = 0; i < WIN - 1; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[WIN-1] <= din;
        end else if (ctrl.rotate) begin
            for (int i = 0; i < WIN - 1; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[WIN-1] <= win_reg[0];
        end
    end

    // oldest entry is the tap under the multiplier
    assign tap = win_reg[0];

endmodule

### rtl/sgs_divider.sv
`timescale 1ns / 1ps

module sgs_divider #(
    parameter int NUM_W   = 39,
    parameter int Q_W     = 18,
    parameter int DIVISOR = 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    output logic                    done,
    output logic signed [Q_W:0]     quot
);

    // floor division by 2*DIVISOR: reciprocal multiply gives a low estimate,
    // compare and subtract steps then settle the quotient
    localparam longint            DV     = 2 * longint'(DIVISOR);
    localparam int                DV_W   = $clog2(DV + 1);
    localparam int                SH     = (NUM_W > 32) ? NUM_W - 32 : 0;
    localparam int                HI_W   = NUM_W - SH;
    localparam int                P      = DV_W + 31;
    localparam logic [31:0]       RECIP  = 32'((64'd1 << P) / DV);
    localparam logic [DV_W-1:0]   DV_C   = DV_W'(DV);
    localparam logic [NUM_W-1:0]  DV_CMP = NUM_W'(DV);

    typedef enum logic [2:0] {
        DV_IDLE,
        DV_ABS,
        DV_MUL,
        DV_EST,
        DV_REM,
        DV_CORR,
        DV_FIX
    } dv_state_t;

    dv_state_t               state_reg;
    logic signed [NUM_W-1:0] num_reg;
    logic                    neg_reg;
    logic [NUM_W-1:0]        mag_reg;
    logic [HI_W+31:0]        prod_reg;
    logic [NUM_W-1:0]        back_reg;
    logic [NUM_W-1:0]        rem_reg;
    logic [Q_W-1:0]          q_reg;
    logic                    done_reg;
    logic signed [Q_W:0]     quot_reg;

    logic [Q_W-1:0]          q_est;
    logic [Q_W+DV_W-1:0]     back_full;
    logic signed [Q_W:0]     q_pos;

    assign q_est     = prod_reg[P-SH +: Q_W];
    assign back_full = q_est * DV_C;
    assign q_pos     = $signed({1'b0, q_reg});

    // divide the magnitude, then apply the floor fixup for negative numerators
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                DV_IDLE: begin
                    if (start) begin
                        num_reg   <= num;
                        neg_reg   <= num[NUM_W-1];
                        state_reg <= DV_ABS;
                    end
                end
                DV_ABS: begin
                    mag_reg   <= neg_reg ? NUM_W'(-num_reg) : NUM_W'(num_reg);
                    state_reg <= DV_MUL;
                end
                DV_MUL: begin
                    prod_reg  <= mag_reg[NUM_W-1:SH] * RECIP;
                    state_reg <= DV_EST;
                end
                DV_EST: begin
                    q_reg     <= q_est;
                    back_reg  <= NUM_W'(back_full);
                    state_reg <= DV_REM;
                end
                DV_REM: begin
                    rem_reg   <= mag_reg - back_reg;
                    state_reg <= DV_CORR;
                end
                DV_CORR: begin
                    // estimate is never high, step it up while a divisor remains
                    if (rem_reg >= DV_CMP) begin
                        rem_reg <= rem_reg - DV_CMP;
                        q_reg   <= q_reg + 1'b1;
                    end else begin
                        state_reg <= DV_FIX;
                    end
                end
                DV_FIX: begin
                    quot_reg  <= neg_reg ? (-q_pos - $signed((Q_W + 1)'(rem_reg != '0)))
                                         : q_pos;
                    done_reg  <= 1'b1;
                    state_reg <= DV_IDLE;
                end
                default: state_reg <= DV_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
